/* hdl/cse_pkg.sv */
// Shared types, widths and codes of the Chebyshev series evaluator.
package cse_pkg;

    localparam int COEF_W     = 64;
    localparam int TIME_W     = 33;
    localparam int CADDR_W    = 9;
    localparam int SUB_W      = 5;
    localparam int TC_W       = 32;
    localparam int NC_W       = 6;
    localparam int ND_W       = 3;
    localparam int AX_W       = 16;
    localparam int VS_W       = 48;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 48;

    localparam logic [CFG_IDX_W-1:0] CFG_NUM_COEFFS  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_NUM_SUBINT  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_NUM_DIMS    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_RECORD_BASE = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_VEL_ENABLE  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_VEL_SCALE   = 3'd5;

    localparam logic CMD_WRITE = 1'b0;
    localparam logic CMD_EVAL  = 1'b1;

    typedef struct packed {
        logic                     is_eval;
        logic [CADDR_W-1:0]       addr;
        logic [COEF_W-1:0]        value;
        logic [SUB_W-1:0]         sub;
        logic signed [TC_W-1:0]   tc;
    } t_job;

    typedef struct packed {
        logic [4:0]         num_coeffs;
        logic [1:0]         num_dims;
        logic [CADDR_W-1:0] record_base;
        logic               vel_enable;
        logic [VS_W-1:0]    vel_scale;
    } t_cfg;

    typedef enum logic [3:0] {
        B_IDLE,
        B_INIT,
        B_TMUL,
        B_TUPD,
        B_MAC,
        B_DRAIN,
        B_FIN1,
        B_FIN2,
        B_FIN3,
        B_OUT
    } t_bstate;

endpackage

/* hdl/cse_if.sv */
// Request and result channel interfaces of the Chebyshev series evaluator.
interface cse_req_if;
    logic               valid;
    logic               ready;
    logic               cmd;
    logic [8:0]         coef_addr;
    logic signed [63:0] coef_value;
    logic [32:0]        time_frac;

    modport source(output valid, output cmd, output coef_addr, output coef_value,
                   output time_frac, input ready);
    modport sink(input valid, input cmd, input coef_addr, input coef_value,
                 input time_frac, output ready);
endinterface

interface cse_rsp_if;
    logic               valid;
    logic               ready;
    logic [1:0]         component;
    logic signed [63:0] position;
    logic signed [63:0] velocity;
    logic               range_error;
    logic               last;

    modport source(output valid, output component, output position, output velocity,
                   output range_error, output last, input ready);
    modport sink(input valid, input component, input position, input velocity,
                 input range_error, input last, output ready);
endinterface

/* hdl/cse_front.sv */
// Front end: classify requests, pick the subinterval and form tc.
module cse_front #(
    parameter int MAX_SUBINTERVALS = 8
) (
    cse_req_if.sink      i_req,
    input  logic [3:0]   i_num_subint,
    input  logic         i_full,
    output logic         o_push,
    output cse_pkg::t_job o_job
);
    import cse_pkg::*;

    logic [5:0]  ns;
    logic [32:0] t;
    logic [38:0] scaled;
    logic [5:0]  sub;
    logic [31:0] frac;

    always_comb begin
        if (i_num_subint == 4'd0) begin
            ns = 6'd1;
        end else if (32'(i_num_subint) > MAX_SUBINTERVALS) begin
            ns = 6'(MAX_SUBINTERVALS);
        end else begin
            ns = {2'b00, i_num_subint};
        end
        // anything above 1.0 counts as exactly 1.0
        t      = (i_req.time_frac > 33'h1_0000_0000) ? 33'h1_0000_0000 : i_req.time_frac;
        scaled = 39'(ns) * 39'(t);
        sub    = scaled[37:32];
        frac   = scaled[31:0];

        o_job.is_eval = (i_req.cmd == CMD_EVAL);
        o_job.addr    = i_req.coef_addr;
        o_job.value   = i_req.coef_value;
        if (sub >= ns) begin
            // end of span: last subinterval, tc = 1.0
            o_job.sub = 5'(ns - 6'd1);
            o_job.tc  = 32'sh4000_0000;
        end else begin
            o_job.sub = sub[4:0];
            o_job.tc  = $signed({1'b0, frac[31:1]}) - 32'sh4000_0000;
        end
    end

    assign i_req.ready = !i_full;
    assign o_push      = i_req.valid && !i_full;

endmodule

/* hdl/cse_fifo.sv */
// Short job queue between front and back end.
module cse_fifo #(
    parameter int DEPTH = 2
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  cse_pkg::t_job i_data,
    output logic          o_full,
    input  logic          i_pop,
    output logic          o_valid,
    output cse_pkg::t_job o_data
);
    import cse_pkg::*;

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    t_job          r_mem [DEPTH];
    logic [PW-1:0] r_wr, r_rd;
    logic [CW-1:0] r_cnt;
    logic          do_push, do_pop;

    assign o_full  = (r_cnt == CW'(DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_data  = r_mem[r_rd];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) begin
                r_wr <= (r_wr == PW'(DEPTH - 1)) ? '0 : r_wr + PW'(1);
            end
            if (do_pop) begin
                r_rd <= (r_rd == PW'(DEPTH - 1)) ? '0 : r_rd + PW'(1);
            end
            if (do_push && !do_pop) begin
                r_cnt <= r_cnt + CW'(1);
            end else if (do_pop && !do_push) begin
                r_cnt <= r_cnt - CW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

endmodule

/* hdl/cse_back.sv */
// Back end: coefficient store, T/T' recurrence, multiply-accumulate and velocity scaling.
module cse_back #(
    parameter int MAX_COEFFS  = 16,
    parameter int MAX_DIMS    = 3,
    parameter int STORE_DEPTH = 512
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    input  cse_pkg::t_job i_job,
    output logic          o_pop,
    input  cse_pkg::t_cfg i_cfg,
    cse_rsp_if.source     o_rsp
);
    import cse_pkg::*;

    localparam int KIW   = (MAX_COEFFS > 1) ? $clog2(MAX_COEFFS) : 1;
    localparam int SAW   = $clog2(STORE_DEPTH);
    localparam int ACC_W = 112;
    localparam int PR_W  = 75;
    localparam logic signed [31:0] ONE_P  = 32'sh4000_0000;
    localparam logic signed [40:0] ONE_V  = 41'sd1073741824;
    localparam logic signed [47:0] TP_MAX = 48'sh0000_7FFF_FFFF;
    localparam logic signed [47:0] TP_MIN = -48'sh0000_8000_0000;
    localparam logic signed [47:0] TV_MAX = 48'sh00FF_FFFF_FFFF;
    localparam logic signed [47:0] TV_MIN = -48'sh0100_0000_0000;

    function automatic logic signed [63:0] sat64(input logic signed [ACC_W-1:0] x);
        logic signed [63:0] r;
        if ((&x[ACC_W-1:63]) || !(|x[ACC_W-1:63])) begin
            r = x[63:0];
        end else if (x[ACC_W-1]) begin
            r = {1'b1, 63'd0};
        end else begin
            r = {1'b0, {63{1'b1}}};
        end
        return r;
    endfunction

    t_bstate r_state, n_state;

    logic [COEF_W-1:0]      r_mem [STORE_DEPTH];
    logic [NC_W-1:0]        r_nc, r_k;
    logic [ND_W-1:0]        r_nd, r_dim;
    logic [SUB_W-1:0]       r_sub;
    logic signed [TC_W-1:0] r_tc;
    logic signed [31:0]     r_p1, r_p2;
    logic signed [40:0]     r_v1, r_v2;
    logic signed [31:0]     r_tp [MAX_COEFFS];
    logic signed [40:0]     r_tv [MAX_COEFFS];
    logic [AX_W-1:0]        r_addr;
    logic                   r_err, r_sticky;
    logic [COEF_W-1:0]      r_rd_data;
    logic                   r_rd_oob;
    logic signed [31:0]     r_tq_p;
    logic signed [40:0]     r_tq_v;
    logic                   r_s1, r_s2;
    logic signed [PR_W-1:0] r_prod [4];
    logic signed [ACC_W-1:0] r_acc_p, r_acc_v;
    logic signed [63:0]     r_pos, r_d;

    logic                   r_o_valid;
    logic [1:0]             r_o_comp;
    logic signed [63:0]     r_o_pos, r_o_vel;
    logic                   r_o_err, r_o_last;

    logic [NC_W-1:0]        nc_cl;
    logic [ND_W-1:0]        nd_cl;
    logic [AX_W-1:0]        base, span, wr_ax;
    logic                   end_oob, wr_ok;
    logic signed [32:0]     twotc;
    logic signed [47:0]     tp_raw, tv_raw;
    logic signed [31:0]     tp_new;
    logic signed [40:0]     tv_new;
    logic [COEF_W-1:0]      coef;
    logic signed [32:0]     m_a [4];
    logic signed [41:0]     m_b [4];
    logic signed [ACC_W-1:0] vsum;
    logic signed [63:0]     vel;

    // register clamps
    always_comb begin
        if (i_cfg.num_coeffs < 5'd3) begin
            nc_cl = NC_W'(3);
        end else if (32'(i_cfg.num_coeffs) > MAX_COEFFS) begin
            nc_cl = NC_W'(MAX_COEFFS);
        end else begin
            nc_cl = NC_W'(i_cfg.num_coeffs);
        end
        if (i_cfg.num_dims == 2'd0) begin
            nd_cl = ND_W'(1);
        end else if (32'(i_cfg.num_dims) > MAX_DIMS) begin
            nd_cl = ND_W'(MAX_DIMS);
        end else begin
            nd_cl = ND_W'(i_cfg.num_dims);
        end
    end

    assign span    = AX_W'(r_nc) * AX_W'(r_nd);
    assign base    = AX_W'(i_cfg.record_base) + AX_W'(r_sub) * span;
    assign end_oob = (base + span) > AX_W'(STORE_DEPTH);
    assign wr_ax   = AX_W'(i_job.addr);
    assign wr_ok   = wr_ax < AX_W'(STORE_DEPTH);
    assign twotc   = 33'(r_tc) <<< 1;

    // recurrence update from the registered products
    always_comb begin
        tp_raw = 48'(r_prod[0] >>> 30) - 48'(r_p2);
        tv_raw = 48'(r_prod[1] >>> 30) + (48'(r_p1) <<< 1) - 48'(r_v2);
        if (tp_raw > TP_MAX) begin
            tp_new = TP_MAX[31:0];
        end else if (tp_raw < TP_MIN) begin
            tp_new = TP_MIN[31:0];
        end else begin
            tp_new = tp_raw[31:0];
        end
        if (tv_raw > TV_MAX) begin
            tv_new = TV_MAX[40:0];
        end else if (tv_raw < TV_MIN) begin
            tv_new = TV_MIN[40:0];
        end else begin
            tv_new = tv_raw[40:0];
        end
    end

    // operand select for the four shared multipliers
    assign coef = r_rd_oob ? '0 : r_rd_data;
    always_comb begin
        for (int i = 0; i < 4; i++) begin
            m_a[i] = '0;
            m_b[i] = '0;
        end
        if (r_s1) begin
            m_a[0] = {1'b0, coef[31:0]};
            m_a[1] = {coef[63], coef[63:32]};
            m_a[2] = {1'b0, coef[31:0]};
            m_a[3] = {coef[63], coef[63:32]};
            m_b[0] = 42'(r_tq_p);
            m_b[1] = 42'(r_tq_p);
            m_b[2] = 42'(r_tq_v);
            m_b[3] = 42'(r_tq_v);
        end else if (r_state == B_TMUL) begin
            m_a[0] = twotc;
            m_a[1] = twotc;
            m_b[0] = 42'(r_p1);
            m_b[1] = 42'(r_v1);
        end else begin
            m_a[0] = {1'b0, r_d[31:0]};
            m_a[1] = {1'b0, r_d[31:0]};
            m_a[2] = {r_d[63], r_d[63:32]};
            m_a[3] = {r_d[63], r_d[63:32]};
            m_b[0] = {18'd0, i_cfg.vel_scale[23:0]};
            m_b[1] = {18'd0, i_cfg.vel_scale[47:24]};
            m_b[2] = {18'd0, i_cfg.vel_scale[23:0]};
            m_b[3] = {18'd0, i_cfg.vel_scale[47:24]};
        end
    end

    assign vsum = (ACC_W'(r_prod[3]) <<< 56) + (ACC_W'(r_prod[2]) <<< 32)
                + (ACC_W'(r_prod[1]) <<< 24) + ACC_W'(r_prod[0]);
    assign vel  = sat64(vsum >>> 40);

    // next state
    always_comb begin
        n_state = r_state;
        o_pop   = 1'b0;
        case (r_state)
            B_IDLE: begin
                if (i_valid) begin
                    o_pop = 1'b1;
                    if (i_job.is_eval) begin
                        n_state = B_INIT;
                    end
                end
            end
            B_INIT: n_state = B_TMUL;
            B_TMUL: n_state = B_TUPD;
            B_TUPD: n_state = (r_k + NC_W'(1) == r_nc) ? B_MAC : B_TMUL;
            B_MAC: begin
                if (r_k == r_nc - NC_W'(1)) begin
                    n_state = B_DRAIN;
                end
            end
            B_DRAIN: begin
                if (!r_s1 && !r_s2) begin
                    n_state = B_FIN1;
                end
            end
            B_FIN1: n_state = B_FIN2;
            B_FIN2: n_state = B_FIN3;
            B_FIN3: n_state = B_OUT;
            B_OUT: begin
                if (o_rsp.ready) begin
                    n_state = (r_dim + ND_W'(1) == r_nd) ? B_IDLE : B_MAC;
                end
            end
            default: n_state = B_IDLE;
        endcase
    end

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= B_IDLE;
            r_sticky  <= 1'b0;
            r_s1      <= 1'b0;
            r_s2      <= 1'b0;
            r_o_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_s1    <= (r_state == B_MAC);
            r_s2    <= r_s1;
            if (r_state == B_IDLE && i_valid && !i_job.is_eval && !wr_ok) begin
                r_sticky <= 1'b1;
            end
            if (r_state == B_INIT) begin
                r_sticky <= 1'b0;
            end
            if (r_state == B_FIN3) begin
                r_o_valid <= 1'b1;
            end else if (r_state == B_OUT && o_rsp.ready) begin
                r_o_valid <= 1'b0;
            end
        end
    end

    // coefficient store
    always_ff @(posedge i_clk) begin
        if (r_state == B_IDLE && i_valid && !i_job.is_eval && wr_ok) begin
            r_mem[wr_ax[SAW-1:0]] <= i_job.value;
        end
        if (r_state == B_MAC) begin
            r_rd_data <= r_mem[r_addr[SAW-1:0]];
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        for (int i = 0; i < 4; i++) begin
            r_prod[i] <= PR_W'(m_a[i]) * PR_W'(m_b[i]);
        end
        case (r_state)
            B_IDLE: begin
                if (i_valid && i_job.is_eval) begin
                    r_sub <= i_job.sub;
                    r_tc  <= i_job.tc;
                    r_nc  <= nc_cl;
                    r_nd  <= nd_cl;
                end
            end
            B_INIT: begin
                r_addr  <= base;
                r_err   <= r_sticky || end_oob;
                r_tp[0] <= ONE_P;
                r_tp[1] <= r_tc;
                r_tv[0] <= '0;
                r_tv[1] <= ONE_V;
                r_p1    <= r_tc;
                r_p2    <= ONE_P;
                r_v1    <= ONE_V;
                r_v2    <= '0;
                r_k     <= NC_W'(2);
                r_dim   <= '0;
                r_acc_p <= '0;
                r_acc_v <= '0;
            end
            B_TUPD: begin
                r_tp[r_k[KIW-1:0]] <= tp_new;
                r_tv[r_k[KIW-1:0]] <= tv_new;
                r_p2 <= r_p1;
                r_p1 <= tp_new;
                r_v2 <= r_v1;
                r_v1 <= tv_new;
                r_k  <= (r_k + NC_W'(1) == r_nc) ? '0 : r_k + NC_W'(1);
            end
            B_MAC: begin
                r_rd_oob <= r_addr >= AX_W'(STORE_DEPTH);
                r_tq_p   <= r_tp[r_k[KIW-1:0]];
                r_tq_v   <= r_tv[r_k[KIW-1:0]];
                r_addr   <= r_addr + AX_W'(1);
                r_k      <= r_k + NC_W'(1);
            end
            B_FIN1: begin
                r_pos <= sat64(r_acc_p >>> 30);
                r_d   <= sat64(r_acc_v >>> 30);
            end
            B_FIN3: begin
                r_o_comp <= r_dim[1:0];
                r_o_pos  <= r_pos;
                r_o_vel  <= i_cfg.vel_enable ? vel : '0;
                r_o_err  <= r_err;
                r_o_last <= (r_dim + ND_W'(1) == r_nd);
            end
            B_OUT: begin
                if (o_rsp.ready) begin
                    r_dim   <= r_dim + ND_W'(1);
                    r_k     <= '0;
                    r_acc_p <= '0;
                    r_acc_v <= '0;
                end
            end
            default: ;
        endcase
        if (r_s2) begin
            r_acc_p <= r_acc_p + (ACC_W'(r_prod[1]) <<< 32) + ACC_W'(r_prod[0]);
            r_acc_v <= r_acc_v + (ACC_W'(r_prod[3]) <<< 32) + ACC_W'(r_prod[2]);
        end
    end

    assign o_rsp.valid       = r_o_valid;
    assign o_rsp.component   = r_o_comp;
    assign o_rsp.position    = r_o_pos;
    assign o_rsp.velocity    = r_o_vel;
    assign o_rsp.range_error = r_o_err;
    assign o_rsp.last        = r_o_last;

endmodule

/* hdl/chebyshev_series_eval_top.sv */
// Top level of the piecewise Chebyshev series evaluator.
//
//  port       dir  kind          what moves
//  i_req      in   valid/ready   request: coefficient write or evaluate at time
//  o_rsp      out  valid/ready   one result per component of an evaluation
//  i_cfg_*    in   write only    register index and data, taken when i_cfg_we
//
// A write request is taken while the back end is idle. Each T/T' recurrence
// step passes through B_TMUL and B_TUPD on the shared multiplier bank; then one
// coefficient per cycle goes through the store read port and the accumulators.
// Reset is synchronous and active low; it clears control and the configuration
// registers, and the store stays undefined until written, so no clearing pass
// is needed. The job queue decouples the sides: requests are accepted until
// the two-entry queue fills, while a result waits in the output register for
// o_rsp.ready.
module chebyshev_series_eval_top #(
    parameter int MAX_COEFFS       = 16,
    parameter int MAX_SUBINTERVALS = 8,
    parameter int MAX_DIMS         = 3,
    parameter int STORE_DEPTH      = 512
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    cse_req_if.sink                            i_req,
    cse_rsp_if.source                          o_rsp,
    input  logic                               i_cfg_we,
    input  logic [cse_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  logic [cse_pkg::CFG_DATA_W-1:0]     i_cfg_wdata
);
    import cse_pkg::*;

    localparam int QUEUE_DEPTH = 2;

    // configuration registers
    logic [4:0]         r_num_coeffs;
    logic [3:0]         r_num_subint;
    logic [1:0]         r_num_dims;
    logic [CADDR_W-1:0] r_record_base;
    logic               r_vel_enable;
    logic [VS_W-1:0]    r_vel_scale;

    t_cfg cfg;
    t_job front_job, queue_job;
    logic front_push, queue_full, queue_valid, back_pop;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_num_coeffs  <= 5'd3;
            r_num_subint  <= 4'd1;
            r_num_dims    <= 2'd3;
            r_record_base <= '0;
            r_vel_enable  <= 1'b0;
            r_vel_scale   <= '0;
        end else if (i_cfg_we) begin
            // drop writes to indexes outside the register list
            case (i_cfg_idx)
                CFG_NUM_COEFFS:  r_num_coeffs  <= i_cfg_wdata[4:0];
                CFG_NUM_SUBINT:  r_num_subint  <= i_cfg_wdata[3:0];
                CFG_NUM_DIMS:    r_num_dims    <= i_cfg_wdata[1:0];
                CFG_RECORD_BASE: r_record_base <= i_cfg_wdata[CADDR_W-1:0];
                CFG_VEL_ENABLE:  r_vel_enable  <= i_cfg_wdata[0];
                CFG_VEL_SCALE:   r_vel_scale   <= i_cfg_wdata[VS_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        cfg.num_coeffs  = r_num_coeffs;
        cfg.num_dims    = r_num_dims;
        cfg.record_base = r_record_base;
        cfg.vel_enable  = r_vel_enable;
        cfg.vel_scale   = r_vel_scale;
    end

    // classify requests and map time to subinterval and tc
    cse_front #(
        .MAX_SUBINTERVALS(MAX_SUBINTERVALS)
    ) u_front (
        .i_req        (i_req),
        .i_num_subint (r_num_subint),
        .i_full       (queue_full),
        .o_push       (front_push),
        .o_job        (front_job)
    );

    // hold classified jobs until the back end is free
    cse_fifo #(
        .DEPTH(QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (front_push),
        .i_data  (front_job),
        .o_full  (queue_full),
        .i_pop   (back_pop),
        .o_valid (queue_valid),
        .o_data  (queue_job)
    );

    // store writes, recurrence, accumulation and velocity scaling
    cse_back #(
        .MAX_COEFFS  (MAX_COEFFS),
        .MAX_DIMS    (MAX_DIMS),
        .STORE_DEPTH (STORE_DEPTH)
    ) u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (queue_valid),
        .i_job   (queue_job),
        .o_pop   (back_pop),
        .i_cfg   (cfg),
        .o_rsp   (o_rsp)
    );

endmodule
